/* sv/lrn_pkg.sv */
package lrn_pkg;

    localparam int CNT_W      = 7;
    localparam int DEN_W      = 24;
    localparam int SCALE_W    = 24;
    localparam int VAR_W      = 33;
    localparam int ROOT_W     = 21;
    localparam int SQRT_W     = 42;
    localparam int SQRT_STEPS = 21;

    localparam logic [1:0] REG_NORM_MODE     = 2'd0;
    localparam logic [1:0] REG_FUSE_RESIDUAL = 2'd1;
    localparam logic [1:0] REG_EPSILON       = 2'd2;
    localparam logic [1:0] REG_ROW_LENGTH    = 2'd3;

    localparam logic [23:0] EPSILON_RESET    = 24'd168;
    localparam logic [6:0]  ROW_LENGTH_RESET = 7'd64;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_VAR,
        DIV_INV
    } t_div_sel;

    typedef struct packed {
        logic signed [15:0] value;
        logic signed [15:0] residual;
        logic signed [15:0] gain;
        logic signed [15:0] bias;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] normalized;
        logic signed [15:0] scaled_value;
        logic signed [15:0] row_mean;
        logic [23:0]        row_scale;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic        norm_mode;
        logic        fuse_residual;
        logic [23:0] epsilon;
        logic [6:0]  row_length;
    } t_cfg;

    typedef struct packed {
        logic             rd;
        logic             rd_emit;
        logic             rd_last;
        logic [CNT_W-1:0] rd_addr;
        logic [CNT_W-1:0] fill;
        logic             div_start;
        t_div_sel         div_sel;
        logic             sqrt_start;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic sq_done;
        logic emit_done;
        logic out_free;
    } t_sts;

endpackage

/* sv/lrn_ram.sv */
module lrn_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/lrn_ctrl.sv */
module lrn_ctrl #(
    parameter int MAX_ROW = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [23:0]       i_cfg_data,
    output lrn_pkg::t_cfg     o_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output lrn_pkg::t_cmd     o_cmd,
    input  lrn_pkg::t_sts     i_sts
);

    localparam int CW = $clog2(MAX_ROW + 1);

    typedef enum logic [3:0] {
        S_LOAD,
        S_MEAN,
        S_SQ,
        S_SQ_WAIT,
        S_VAR,
        S_SQRT,
        S_INV,
        S_EMIT_ISSUE,
        S_EMIT_WAIT
    } t_state;

    t_state        r_state;
    lrn_pkg::t_cfg r_cfg;
    lrn_pkg::t_cmd r_cmd;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_idx;
    logic          r_last;

    logic [CW-1:0] w_len;
    logic [CW-1:0] w_fill_inc;
    logic          w_accept;
    logic          w_idx_last;

    always_comb begin
        if (r_cfg.row_length == 7'd0) begin
            w_len = CW'(1);
        end else if (r_cfg.row_length > 7'(MAX_ROW)) begin
            w_len = CW'(MAX_ROW);
        end else begin
            w_len = CW'(r_cfg.row_length);
        end
    end

    assign w_accept   = i_in_valid && (r_state == S_LOAD);
    assign w_fill_inc = r_fill + CW'(1);
    assign w_idx_last = (r_idx == r_n - CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state                <= S_LOAD;
            r_cfg.norm_mode        <= 1'b0;
            r_cfg.fuse_residual    <= 1'b0;
            r_cfg.epsilon          <= lrn_pkg::EPSILON_RESET;
            r_cfg.row_length       <= lrn_pkg::ROW_LENGTH_RESET;
            r_cmd                  <= '0;
            r_fill                 <= '0;
            r_n                    <= '0;
            r_idx                  <= '0;
            r_last                 <= 1'b0;
        end else begin
            r_cmd.rd         <= 1'b0;
            r_cmd.div_start  <= 1'b0;
            r_cmd.sqrt_start <= 1'b0;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    lrn_pkg::REG_NORM_MODE:     r_cfg.norm_mode     <= i_cfg_data[0];
                    lrn_pkg::REG_FUSE_RESIDUAL: r_cfg.fuse_residual <= i_cfg_data[0];
                    lrn_pkg::REG_EPSILON:       r_cfg.epsilon       <= i_cfg_data;
                    lrn_pkg::REG_ROW_LENGTH:    r_cfg.row_length    <= i_cfg_data[6:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (w_fill_inc >= w_len) begin
                            r_fill <= '0;
                            r_n    <= w_fill_inc;
                            r_idx  <= '0;
                            if (r_cfg.norm_mode) begin
                                r_state <= S_SQ;
                            end else begin
                                r_cmd.div_start <= 1'b1;
                                r_cmd.div_sel   <= lrn_pkg::DIV_MEAN;
                                r_state         <= S_MEAN;
                            end
                        end else begin
                            r_fill <= w_fill_inc;
                        end
                    end
                end
                S_MEAN: begin
                    if (i_sts.div_done) begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_cmd.rd      <= 1'b1;
                    r_cmd.rd_emit <= 1'b0;
                    r_cmd.rd_addr <= lrn_pkg::CNT_W'(r_idx);
                    r_cmd.rd_last <= w_idx_last;
                    if (w_idx_last) begin
                        r_state <= S_SQ_WAIT;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_SQ_WAIT: begin
                    if (i_sts.sq_done) begin
                        r_cmd.div_start <= 1'b1;
                        r_cmd.div_sel   <= lrn_pkg::DIV_VAR;
                        r_state         <= S_VAR;
                    end
                end
                S_VAR: begin
                    if (i_sts.div_done) begin
                        r_cmd.sqrt_start <= 1'b1;
                        r_state          <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (i_sts.sqrt_done) begin
                        r_cmd.div_start <= 1'b1;
                        r_cmd.div_sel   <= lrn_pkg::DIV_INV;
                        r_state         <= S_INV;
                    end
                end
                S_INV: begin
                    if (i_sts.div_done) begin
                        r_idx   <= '0;
                        r_state <= S_EMIT_ISSUE;
                    end
                end
                S_EMIT_ISSUE: begin
                    if (i_sts.out_free) begin
                        r_cmd.rd      <= 1'b1;
                        r_cmd.rd_emit <= 1'b1;
                        r_cmd.rd_addr <= lrn_pkg::CNT_W'(r_idx);
                        r_cmd.rd_last <= w_idx_last;
                        r_last        <= w_idx_last;
                        r_state       <= S_EMIT_WAIT;
                    end
                end
                S_EMIT_WAIT: begin
                    if (i_sts.emit_done) begin
                        if (r_last) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + CW'(1);
                            r_state <= S_EMIT_ISSUE;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd      = r_cmd;
        o_cmd.fill = lrn_pkg::CNT_W'(r_fill);
    end

    assign o_cfg       = r_cfg;
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_LOAD);

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < CW'(MAX_ROW))
        else $error("fill count out of range");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_MEAN || r_state == S_VAR || r_state == S_INV))
        else $error("divider finished outside a wait state");

    a_sqrt_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.sqrt_done |-> r_state == S_SQRT)
        else $error("square root finished outside its wait state");

    a_emit_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.emit_done |-> (r_state == S_EMIT_WAIT && !i_sts.out_free))
        else $error("result landed outside emit wait");

endmodule

/* sv/lrn_dp.sv */
module lrn_dp #(
    parameter int MAX_ROW = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lrn_pkg::t_cfg      i_cfg,
    input  lrn_pkg::t_cmd      i_cmd,
    input  logic               i_accept,
    input  lrn_pkg::t_in_item  i_item,
    output lrn_pkg::t_sts      o_sts,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lrn_pkg::t_out_item o_out_item
);

    localparam int AW    = $clog2(MAX_ROW);
    localparam int CW    = $clog2(MAX_ROW + 1);
    localparam int SUM_W = 16 + CW;
    localparam int NUM_W = 32 + CW;
    localparam int DCW   = $clog2(NUM_W + 1);
    localparam int SCW   = $clog2(lrn_pkg::SQRT_STEPS + 1);
    localparam int DEN_W = lrn_pkg::DEN_W;
    localparam int ROOT_W = lrn_pkg::ROOT_W;

    function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
        if (v > 26'sd32767) begin
            return 16'sh7fff;
        end else if (v < -26'sd32768) begin
            return -16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic logic signed [25:0] rnd16(input logic signed [41:0] v);
        logic signed [41:0] t;
        if (v >= 0) begin
            t = (v + 42'sd32768) >>> 16;
        end else begin
            t = -((-v + 42'sd32768) >>> 16);
        end
        return t[25:0];
    endfunction

    function automatic logic signed [20:0] rnd12(input logic signed [32:0] v);
        logic signed [32:0] t;
        if (v >= 0) begin
            t = (v + 33'sd2048) >>> 12;
        end else begin
            t = -((-v + 33'sd2048) >>> 12);
        end
        return t[20:0];
    endfunction

    // load side
    logic signed [16:0] w_fsum;
    logic signed [15:0] w_x_in;
    logic [47:0]        w_rdata;

    assign w_fsum = 17'(i_item.value) + 17'(i_item.residual);
    assign w_x_in = (i_cfg.fuse_residual && !i_cfg.norm_mode) ? sat16(26'(w_fsum))
                                                              : i_item.value;

    lrn_ram #(
        .WIDTH (48),
        .DEPTH (MAX_ROW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_accept),
        .i_waddr (i_cmd.fill[AW-1:0]),
        .i_wdata ({w_x_in, i_item.gain, i_item.bias}),
        .i_re    (i_cmd.rd),
        .i_raddr (i_cmd.rd_addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    logic signed [SUM_W-1:0] r_sum;
    logic [CW-1:0]           r_n;
    logic                    r_rms;
    logic signed [15:0]      r_mean;
    logic [NUM_W-1:0]        r_sq;
    logic [lrn_pkg::VAR_W-1:0] r_var;
    logic [23:0]             r_inv;

    // read pipeline
    logic               r_rd_v, r_rd_emit, r_rd_last;
    logic               r_prod_v, r_prod_last, r_sq_done;
    logic [31:0]        r_prod;
    logic               r_e1_v, r_e1_last;
    logic signed [41:0] r_p;
    logic signed [15:0] r_g1, r_b1;
    logic               r_e2_v, r_e2_last, r_emit_done;
    logic signed [32:0] r_acc;
    logic signed [15:0] r_nv;
    logic               r_out_v;
    lrn_pkg::t_out_item r_out;

    logic signed [15:0] w_rx, w_rg, w_rb;
    logic signed [16:0] w_d;
    logic signed [33:0] w_dd;
    logic signed [41:0] w_p;
    logic signed [15:0] w_nv;
    logic signed [32:0] w_gn, w_bias, w_acc;

    assign w_rx  = w_rdata[47:32];
    assign w_rg  = w_rdata[31:16];
    assign w_rb  = w_rdata[15:0];
    assign w_d   = 17'(w_rx) - 17'(r_mean);
    assign w_dd  = w_d * w_d;
    assign w_p   = w_d * $signed({1'b0, r_inv});
    assign w_nv  = sat16(rnd16(r_p));
    assign w_gn  = r_g1 * w_nv;
    assign w_bias = r_rms ? '0 : {{5{r_b1[15]}}, r_b1, 12'b0};
    assign w_acc = w_gn + w_bias;

    // square root, two bits a step
    logic                   r_sqrt_busy, r_sqrt_done;
    logic [SCW-1:0]         r_sqrt_cnt;
    logic [lrn_pkg::SQRT_W-1:0] r_op;
    logic [ROOT_W+1:0]      r_srem;
    logic [ROOT_W-1:0]      r_root;
    logic [ROOT_W+3:0]      w_st, w_trial, w_ssub;
    logic                   w_sge;

    assign w_st    = {r_srem, r_op[lrn_pkg::SQRT_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ssub  = w_st - w_trial;
    assign w_sge   = (w_st >= w_trial);

    // shared divider
    logic                    r_div_busy, r_div_fin, r_div_done;
    logic [DCW-1:0]          r_div_cnt;
    logic [DEN_W-1:0]        r_rem, r_den;
    logic [NUM_W-1:0]        r_q;
    lrn_pkg::t_div_sel       r_div_sel;
    logic [SUM_W-1:0]        w_abs;
    logic [NUM_W-1:0]        w_num;
    logic [DEN_W-1:0]        w_den;
    logic [DEN_W:0]          w_t, w_tsub;
    logic                    w_ge;
    logic [15:0]             w_q16;

    assign w_abs  = r_sum[SUM_W-1] ? $unsigned(-r_sum) : $unsigned(r_sum);
    assign w_t    = {r_rem, r_q[NUM_W-1]};
    assign w_tsub = w_t - {1'b0, r_den};
    assign w_ge   = (w_t >= {1'b0, r_den});
    assign w_q16  = r_q[15:0];

    always_comb begin
        case (i_cmd.div_sel)
            lrn_pkg::DIV_MEAN: begin
                w_num = NUM_W'(w_abs) + NUM_W'(r_n >> 1);
                w_den = DEN_W'(r_n);
            end
            lrn_pkg::DIV_VAR: begin
                w_num = r_sq;
                w_den = DEN_W'(r_n);
            end
            lrn_pkg::DIV_INV: begin
                w_num = (NUM_W'(1) << 32) + NUM_W'(r_root >> 1);
                w_den = DEN_W'(r_root);
            end
            default: begin
                w_num = '0;
                w_den = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v      <= 1'b0;
            r_prod_v    <= 1'b0;
            r_sq_done   <= 1'b0;
            r_e1_v      <= 1'b0;
            r_e2_v      <= 1'b0;
            r_emit_done <= 1'b0;
            r_out_v     <= 1'b0;
            r_div_busy  <= 1'b0;
            r_div_fin   <= 1'b0;
            r_div_done  <= 1'b0;
            r_sqrt_busy <= 1'b0;
            r_sqrt_done <= 1'b0;
        end else begin
            if (i_accept) begin
                r_sum  <= ((i_cmd.fill == '0) ? '0 : r_sum) + SUM_W'(w_x_in);
                r_n    <= i_cmd.fill[CW-1:0] + CW'(1);
                r_rms  <= i_cfg.norm_mode;
                r_mean <= '0;
                r_sq   <= '0;
            end

            r_rd_v    <= i_cmd.rd;
            r_rd_emit <= i_cmd.rd_emit;
            r_rd_last <= i_cmd.rd_last;

            r_prod_v    <= r_rd_v && !r_rd_emit;
            r_prod_last <= r_rd_last;
            r_prod      <= w_dd[31:0];
            r_sq_done   <= r_prod_v && r_prod_last;
            if (r_prod_v) begin
                r_sq <= r_sq + NUM_W'(r_prod);
            end

            r_e1_v    <= r_rd_v && r_rd_emit;
            r_e1_last <= r_rd_last;
            r_p       <= w_p;
            r_g1      <= w_rg;
            r_b1      <= w_rb;

            r_e2_v    <= r_e1_v;
            r_e2_last <= r_e1_last;
            r_acc     <= w_acc;
            r_nv      <= w_nv;

            r_emit_done <= r_e2_v;
            if (r_e2_v) begin
                r_out_v              <= 1'b1;
                r_out.normalized     <= r_nv;
                r_out.scaled_value   <= sat16(26'(rnd12(r_acc)));
                r_out.row_mean       <= r_mean;
                r_out.row_scale      <= r_rms ? r_inv : lrn_pkg::SCALE_W'(r_root);
                r_out.last           <= r_e2_last;
            end else if (r_out_v && !i_out_stall) begin
                r_out_v <= 1'b0;
            end

            r_div_fin  <= 1'b0;
            r_div_done <= r_div_fin;
            if (i_cmd.div_start) begin
                r_div_busy <= 1'b1;
                r_div_cnt  <= DCW'(NUM_W);
                r_div_sel  <= i_cmd.div_sel;
                r_rem      <= '0;
                r_q        <= w_num;
                r_den      <= w_den;
            end else if (r_div_busy) begin
                r_rem     <= w_ge ? w_tsub[DEN_W-1:0] : w_t[DEN_W-1:0];
                r_q       <= {r_q[NUM_W-2:0], w_ge};
                r_div_cnt <= r_div_cnt - DCW'(1);
                if (r_div_cnt == DCW'(1)) begin
                    r_div_busy <= 1'b0;
                    r_div_fin  <= 1'b1;
                end
            end
            if (r_div_fin) begin
                case (r_div_sel)
                    lrn_pkg::DIV_MEAN: begin
                        r_mean <= r_sum[SUM_W-1] ? $signed(-w_q16) : $signed(w_q16);
                    end
                    lrn_pkg::DIV_VAR: begin
                        r_var <= lrn_pkg::VAR_W'(r_q[31:0]) + lrn_pkg::VAR_W'(i_cfg.epsilon);
                    end
                    lrn_pkg::DIV_INV: begin
                        if (r_root == '0 || (|r_q[NUM_W-1:24])) begin
                            r_inv <= 24'hffffff;
                        end else begin
                            r_inv <= r_q[23:0];
                        end
                    end
                    default: ;
                endcase
            end

            r_sqrt_done <= 1'b0;
            if (i_cmd.sqrt_start) begin
                r_sqrt_busy <= 1'b1;
                r_sqrt_cnt  <= SCW'(lrn_pkg::SQRT_STEPS);
                r_op        <= {1'b0, r_var, 8'b0};
                r_srem      <= '0;
                r_root      <= '0;
            end else if (r_sqrt_busy) begin
                r_srem     <= w_sge ? w_ssub[ROOT_W+1:0] : w_st[ROOT_W+1:0];
                r_root     <= {r_root[ROOT_W-2:0], w_sge};
                r_op       <= {r_op[lrn_pkg::SQRT_W-3:0], 2'b00};
                r_sqrt_cnt <= r_sqrt_cnt - SCW'(1);
                if (r_sqrt_cnt == SCW'(1)) begin
                    r_sqrt_busy <= 1'b0;
                    r_sqrt_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.div_done  = r_div_done;
    assign o_sts.sqrt_done = r_sqrt_done;
    assign o_sts.sq_done   = r_sq_done;
    assign o_sts.emit_done = r_emit_done;
    assign o_sts.out_free  = !r_out_v;
    assign o_out_valid     = r_out_v;
    assign o_out_item      = r_out;

endmodule

/* sv/layer_rms_norm_forward.sv */
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_stall   i_in_item  (value, residual, gain, bias)
// out      output     o_out_valid / i_out_stall o_out_item (normalized ... last)
// cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Elements load at one per cycle while o_in_stall is low. After the last element of a
// row come, in order: mean division (LayerNorm only) on the shared bit-serial divider
// (NUM_W = 32 + clog2(MAX_ROW+1)), the squared pass, variance division on the same
// divider, the square root, the reciprocal division, then the results one at a time
// through the registered-read store, each held back while the output is stalled.
// Input stalls for the whole row computation.
// Reset is synchronous; the element store needs no clearing pass.
module layer_rms_norm_forward #(
    parameter int MAX_ROW = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lrn_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lrn_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    lrn_pkg::t_cfg w_cfg;
    lrn_pkg::t_cmd w_cmd;
    lrn_pkg::t_sts w_sts;
    logic          w_in_ready;
    logic          w_accept;

    assign o_in_stall = !w_in_ready;
    assign w_accept   = i_in_valid && w_in_ready;

    lrn_ctrl #(
        .MAX_ROW (MAX_ROW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (w_in_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    lrn_dp #(
        .MAX_ROW (MAX_ROW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .i_accept    (w_accept),
        .i_item      (i_in_item),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
